### rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk and held off during reset
`define PME_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk and held off during reset
`define PME_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### rtl/pme_pkg.sv
// package for the permutation mutation engine: sizes, op codes, sequencer states
package pme_pkg;

  localparam int MAX_GENES = 64;
  localparam int GENE_AW   = $clog2(MAX_GENES);
  localparam int GENE_W    = 16;
  localparam int COUNT_W   = 7;
  localparam int OP_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_SWAP    = 3'd2,
    OP_MOVE    = 3'd3,
    OP_REVERSE = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDWAIT,
    S_XRD_P,
    S_XRD_Q,
    S_XWR_P,
    S_XWR_Q,
    S_MSRC,
    S_MCAP,
    S_MRD,
    S_MWR,
    S_MLAST,
    S_DONE
  } state_t;

endpackage

### rtl/pme_ram.sv
// generic single-write, single-read memory with registered read data
module pme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/permutation_mutation_engine_core.sv
// top level of the permutation mutation engine: genome store and operation sequencer
//
//   channel  direction  ports                                        purpose
//   in       input      in_op in_index_a in_index_b in_value         one operation word
//   out      output     out_read_value out_out_of_range              one result word per op
//   cfg      input      cfg_data                                     gene_count register
//
// a new word is taken only while idle, once the last word has handed over its result
// swap and reverse read and write one exchanged pair at a time, move one shifted entry at a time
// the genome ram has a single read port: each entry moves through it
// reset restores the identity order through per-entry valid bits, no clearing pass
// a finished result waits in the output register while the next word is taken
`include "assert_macros.svh"

module permutation_mutation_engine_core
  import pme_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [GENE_AW-1:0]  in_index_a,
  input  logic [GENE_AW-1:0]  in_index_b,
  input  logic [GENE_W-1:0]   in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [GENE_W-1:0]   out_read_value,
  output logic                out_out_of_range,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_data
);

  // sequencer state
  state_t              state_r, state_nxt;
  logic [COUNT_W-1:0]  gene_count_r;

  // working pointers: low/high ends for swap and reverse, ptr/dst for move
  logic [GENE_AW-1:0]  lo_r, lo_nxt;
  logic [GENE_AW-1:0]  hi_r, hi_nxt;
  logic                is_rev_r, is_rev_nxt;
  logic                dir_up_r, dir_up_nxt;
  logic [GENE_W-1:0]   tmp_r, tmp_nxt;

  // result waiting to be handed to the output register
  logic [GENE_W-1:0]   res_val_r, res_val_nxt;
  logic                res_bad_r, res_bad_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [GENE_W-1:0]   out_read_value_r, out_read_value_nxt;
  logic                out_out_of_range_r, out_out_of_range_nxt;

  // genome ram ports plus valid overlay for the identity reset
  logic                ram_we;
  logic [GENE_AW-1:0]  ram_waddr;
  logic [GENE_W-1:0]   ram_wdata;
  logic [GENE_AW-1:0]  ram_raddr;
  logic [GENE_W-1:0]   ram_rdata;
  logic [MAX_GENES-1:0] vld_r;
  logic                vld_q_r;
  logic [GENE_AW-1:0]  addr_q_r;
  logic [GENE_W-1:0]   rdval;

  // effective length and bounds checks on the incoming word
  logic [COUNT_W-1:0]  eff_len;
  logic                a_ok, b_ok;
  logic                in_fire;
  logic                out_free;
  logic [GENE_AW-1:0]  step_ptr;
  logic [GENE_AW-1:0]  a_lo, a_hi;

  pme_ram #(
    .WIDTH (GENE_W),
    .DEPTH (MAX_GENES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign eff_len  = (gene_count_r > COUNT_W'(MAX_GENES)) ? COUNT_W'(MAX_GENES) : gene_count_r;
  assign a_ok     = {1'b0, in_index_a} < eff_len;
  assign b_ok     = {1'b0, in_index_b} < eff_len;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign a_lo     = (in_index_a < in_index_b) ? in_index_a : in_index_b;
  assign a_hi     = (in_index_a < in_index_b) ? in_index_b : in_index_a;

  // next entry of a move walk, toward the target
  assign step_ptr = dir_up_r ? (lo_r + GENE_AW'(1)) : (lo_r - GENE_AW'(1));

  // an entry never written still holds its reset value i+1
  assign rdval = vld_q_r ? ram_rdata : (GENE_W'(addr_q_r) + GENE_W'(1));

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_read_value   = out_read_value_r;
  assign out_out_of_range = out_out_of_range_r;

  always_comb begin
    state_nxt   = state_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    is_rev_nxt  = is_rev_r;
    dir_up_nxt  = dir_up_r;
    tmp_nxt     = tmp_r;
    res_val_nxt = res_val_r;
    res_bad_nxt = res_bad_r;
    ram_we      = 1'b0;
    ram_waddr   = lo_r;
    ram_wdata   = rdval;
    ram_raddr   = in_index_a;

    out_valid_nxt        = out_valid_r && !out_ready;
    out_read_value_nxt   = out_read_value_r;
    out_out_of_range_nxt = out_out_of_range_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_val_nxt = '0;
          res_bad_nxt = 1'b0;
          state_nxt   = S_DONE;
          case (in_op)
            OP_READ: begin
              if (a_ok) begin
                state_nxt = S_RDWAIT;
              end else begin
                res_bad_nxt = 1'b1;
              end
            end
            OP_WRITE: begin
              if (a_ok) begin
                ram_we    = 1'b1;
                ram_waddr = in_index_a;
                ram_wdata = in_value;
              end else begin
                res_bad_nxt = 1'b1;
              end
            end
            OP_SWAP, OP_REVERSE: begin
              if (!(a_ok && b_ok)) begin
                res_bad_nxt = 1'b1;
              end else if (in_index_a != in_index_b) begin
                lo_nxt     = a_lo;
                hi_nxt     = a_hi;
                is_rev_nxt = (in_op == OP_REVERSE);
                state_nxt  = S_XRD_P;
              end
            end
            OP_MOVE: begin
              if (!(a_ok && b_ok)) begin
                res_bad_nxt = 1'b1;
              end else if (in_index_a != in_index_b) begin
                lo_nxt     = in_index_a;
                hi_nxt     = in_index_b;
                dir_up_nxt = (in_index_a < in_index_b);
                state_nxt  = S_MSRC;
              end
            end
            default: begin
              // unknown op: no change, plain zero result
            end
          endcase
        end
      end

      S_RDWAIT: begin
        res_val_nxt = rdval;
        state_nxt   = S_DONE;
      end

      // exchange of the entries at lo and hi
      S_XRD_P: begin
        ram_raddr = lo_r;
        state_nxt = S_XRD_Q;
      end
      S_XRD_Q: begin
        ram_raddr = hi_r;
        tmp_nxt   = rdval;
        state_nxt = S_XWR_P;
      end
      S_XWR_P: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = rdval;
        state_nxt = S_XWR_Q;
      end
      S_XWR_Q: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = tmp_r;
        lo_nxt    = lo_r + GENE_AW'(1);
        hi_nxt    = hi_r - GENE_AW'(1);
        // keep walking inward while at least one more pair is left
        if (is_rev_r && (({1'b0, lo_r} + (GENE_AW + 1)'(2)) < {1'b0, hi_r})) begin
          state_nxt = S_XRD_P;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // move: hold the source entry, shift the span by one, drop it at the target
      S_MSRC: begin
        ram_raddr = lo_r;
        state_nxt = S_MCAP;
      end
      S_MCAP: begin
        tmp_nxt   = rdval;
        ram_raddr = step_ptr;
        state_nxt = S_MWR;
      end
      S_MRD: begin
        ram_raddr = step_ptr;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = rdval;
        lo_nxt    = step_ptr;
        state_nxt = (step_ptr == hi_r) ? S_MLAST : S_MRD;
      end
      S_MLAST: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = tmp_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_read_value_nxt   = res_val_r;
          out_out_of_range_nxt = res_bad_r;
          state_nxt            = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      gene_count_r <= COUNT_W'(MAX_GENES);
      vld_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        gene_count_r <= cfg_data;
      end
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    lo_r               <= lo_nxt;
    hi_r               <= hi_nxt;
    is_rev_r           <= is_rev_nxt;
    dir_up_r           <= dir_up_nxt;
    tmp_r              <= tmp_nxt;
    res_val_r          <= res_val_nxt;
    res_bad_r          <= res_bad_nxt;
    out_read_value_r   <= out_read_value_nxt;
    out_out_of_range_r <= out_out_of_range_nxt;
    vld_q_r            <= vld_r[ram_raddr];
    addr_q_r           <= ram_raddr;
  end

  `PME_ASSERT_NXT(a_done_loads_out, (state_r == S_DONE) && out_free, out_valid_r)
  `PME_ASSERT_IMP(a_rev_order, state_r == S_XRD_P, lo_r < hi_r)
  `PME_ASSERT_IMP(a_move_not_at_target, state_r == S_MWR, lo_r != hi_r)
  `PME_ASSERT_IMP(a_bad_reads_zero, out_valid_r && out_out_of_range_r, out_read_value_r == '0)

endmodule
